// ----- hdl/bed_pkg.sv -----
`default_nettype none

package bed_pkg;

    // Character codes the decoder recognizes
    localparam logic [7:0] CHAR_BSLASH  = 8'h5C;
    localparam logic [7:0] CHAR_T       = 8'h74;
    localparam logic [7:0] CHAR_N       = 8'h6E;
    localparam logic [7:0] CHAR_S       = 8'h73;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    localparam int unsigned HEX_RADIX = 16;
    localparam int unsigned NIB_W     = $clog2(HEX_RADIX);

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_TRAIL   = 3'd1,
        ST_MISSING = 3'd2,
        ST_BADHEX  = 3'd3,
        ST_UNKNOWN = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESCAPE = 2'd1,
        MODE_HEX    = 2'd2
    } mode_t;

    // One decoded result plus a flag saying whether the item produces one
    typedef struct packed {
        logic          emit;
        logic [7:0]    out_byte;
        logic          has_byte;
        status_t       status;
        logic          out_last;
    } result_t;

    // Digit value in the low bits; top bit set when the byte is not a hex digit
    function automatic logic [NIB_W:0] hex_value(input logic [7:0] c);
        logic [NIB_W:0] v;
        v = (NIB_W + 1)'(HEX_RADIX);
        if (c >= 8'h30 && c <= 8'h39) begin
            v = (NIB_W + 1)'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = (NIB_W + 1)'(c - 8'h61 + 8'd10);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = (NIB_W + 1)'(c - 8'h41 + 8'd10);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/bed_core.sv -----
`default_nettype none

module bed_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            fire,
    input  wire logic [7:0]      in_byte,
    input  wire logic            in_last,
    output bed_pkg::result_t     result
);
    import bed_pkg::*;

    mode_t             mode_reg, mode_next;
    logic [NIB_W-1:0]  nib_reg, nib_next;
    status_t           err_reg, err_next;

    logic [NIB_W:0]    h;
    logic              is_hex;
    logic              have;
    logic [7:0]        val;

    always_comb begin
        h         = hex_value(in_byte);
        is_hex    = ~h[NIB_W];
        mode_next = mode_reg;
        nib_next  = nib_reg;
        err_next  = err_reg;
        have      = 1'b0;
        val       = 8'd0;

        if (err_reg == ST_OK) begin
            unique case (mode_reg)
                MODE_ESCAPE: begin
                    if (is_hex) begin
                        nib_next  = h[NIB_W-1:0];
                        mode_next = MODE_HEX;
                        if (in_last) err_next = ST_MISSING;
                    end else begin
                        mode_next = MODE_NORMAL;
                        have      = 1'b1;
                        case (in_byte)
                            CHAR_BSLASH: val = CHAR_BSLASH;
                            CHAR_T:      val = CHAR_TAB;
                            CHAR_N:      val = CHAR_NEWLINE;
                            CHAR_S:      val = CHAR_SPACE;
                            default: begin
                                have     = 1'b0;
                                err_next = ST_UNKNOWN;
                            end
                        endcase
                    end
                end
                MODE_HEX: begin
                    mode_next = MODE_NORMAL;
                    if (is_hex) begin
                        val  = {nib_reg, h[NIB_W-1:0]};
                        have = 1'b1;
                    end else begin
                        err_next = ST_BADHEX;
                    end
                end
                default: begin
                    mode_next = MODE_NORMAL;
                    if (in_byte == CHAR_BSLASH) begin
                        mode_next = MODE_ESCAPE;
                        if (in_last) err_next = ST_TRAIL;
                    end else begin
                        val  = in_byte;
                        have = 1'b1;
                    end
                end
            endcase
        end

        result.emit     = have | in_last;
        result.out_byte = val;
        result.has_byte = have;
        result.status   = in_last ? err_next : ST_OK;
        result.out_last = in_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_NORMAL;
            nib_reg  <= '0;
            err_reg  <= ST_OK;
        end else if (fire) begin
            if (in_last) begin
                // end of string: back to the reset state
                mode_reg <= MODE_NORMAL;
                nib_reg  <= '0;
                err_reg  <= ST_OK;
            end else begin
                mode_reg <= mode_next;
                nib_reg  <= nib_next;
                err_reg  <= err_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/backslash_escape_decoder_top.sv -----
`default_nettype none

// Backslash escape decoder. Takes a quoted string one byte per item on the
// s_ channel (s_tlast on its final byte) and gives decoded bytes on the m_
// channel. Ordinary bytes are copied; a backslash plus two hex digits gives
// that byte, and backslash plus backslash, t, n or s gives backslash, tab,
// newline or space. A non-last item that completes nothing (a backslash, a
// first hex digit, anything after an error) gives no result. The final byte
// always gives one result with m_tlast set and the string's status in
// m_tuser; after the first error no further bytes come out. Throughput is
// one item per cycle while m_tready does not hold the result register: each
// item is captured in the input register, decoded by the escape tracker in a
// single pass, and lands in the result register, which drives m_tvalid.
module backslash_escape_decoder_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire logic        s_tlast,   // in_last
    output wire logic        m_tvalid,
    input  wire logic        m_tready,
    output wire logic [7:0]  m_tdata,   // [7:0] out_byte
    output wire logic [3:0]  m_tuser,   // [0] has_byte, [3:1] status
    output wire logic        m_tlast    // out_last
);
    import bed_pkg::*;

    // Input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    // Result register
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_has_reg;
    status_t     out_status_reg;
    logic        out_last_reg;

    logic        out_free;
    logic        fire;
    result_t     result;

    // Result register can load when empty or being drained this cycle
    assign out_free = ~out_valid_reg | m_tready;
    // Hand the buffered item to the decoder whenever the result side can take it
    assign fire     = in_valid_reg & out_free;
    assign s_tready = ~in_valid_reg | out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    bed_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .in_byte (in_byte_reg),
        .in_last (in_last_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            // drop items that complete nothing
            out_valid_reg <= fire & result.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && result.emit) begin
            out_byte_reg   <= result.out_byte;
            out_has_reg    <= result.has_byte;
            out_status_reg <= result.status;
            out_last_reg   <= result.out_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = {out_status_reg, out_has_reg};
    assign m_tlast  = out_last_reg;

    // A status other than ok only travels on the final result of a string
    a_status_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> out_status_reg == ST_OK)
        else $error("error status on a non-final result");

    // Every non-final result carries a byte
    a_nonlast_has_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> out_has_reg)
        else $error("non-final result without a byte");

    // An empty result carries a zero byte
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !out_has_reg |-> out_byte_reg == 8'd0)
        else $error("empty result with nonzero byte");

    // A result with a byte never carries an error status
    a_byte_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_has_reg |-> out_status_reg == ST_OK)
        else $error("decoded byte together with an error status");

endmodule

`default_nettype wire
